### rtl/running_median_two_heaps_defines.svh
// ----------------------------------------------------------------------------
// running median assertion macros
// shared concurrent check forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef RUNNING_MEDIAN_TWO_HEAPS_DEFINES_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_DEFINES_SVH

// condition must hold at every edge out of reset
`define RMH_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RMH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rmh_pkg.sv
// ----------------------------------------------------------------------------
// rmh_pkg
// shared types and field widths of the running median block
// ----------------------------------------------------------------------------
`default_nettype none
package rmh_pkg;

  localparam int unsigned SampleWidth = 16;
  localparam int unsigned CountWidth  = 11;

  // one result beat as produced by the controller
  typedef struct packed {
    logic                   full_res;
    logic [CountWidth-1:0]  stored_count;
    logic [SampleWidth-1:0] median;
  } result_t;

endpackage
`default_nettype wire

### rtl/rmh_ram.sv
// ----------------------------------------------------------------------------
// rmh_ram
// simple dual-port heap storage, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module rmh_ram #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned WIDTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/rmh_ctrl.sv
// ----------------------------------------------------------------------------
// rmh_ctrl
// heap sequencer: sift-up insert, top compare and swap, sift-down repair
// ----------------------------------------------------------------------------
`default_nettype none
`include "running_median_two_heaps_defines.svh"
module rmh_ctrl #(
  parameter int unsigned CAPACITY    = 1024,
  parameter int unsigned VALUE_WIDTH = 16,
  parameter int unsigned SW          = $clog2(CAPACITY + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // sample side
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [15:0]            in_sample,
  // result side
  output logic                        res_valid,
  input  wire logic                   res_ready,
  output rmh_pkg::result_t            res,
  // heap memories
  output logic                        lo_we,
  output logic                        up_we,
  output logic [SW-1:0]               waddr,
  output logic [VALUE_WIDTH-1:0]      wdata,
  output logic [SW-1:0]               raddr,
  input  wire logic [VALUE_WIDTH-1:0] lo_rdata,
  input  wire logic [VALUE_WIDTH-1:0] up_rdata
);

  localparam int unsigned PW = SW + 1;
  localparam int unsigned VW = VALUE_WIDTH;

  typedef enum logic [2:0] {
    ST_IDLE, ST_UP_RD, ST_UP_CMP, ST_SW_CHK,
    ST_DN_RL, ST_DN_RR, ST_DN_CMP, ST_DONE
  } state_t;

  state_t               state_r;
  logic                 sel_r;      // 0 lower max-heap, 1 upper min-heap
  logic [SW-1:0]        pos_r;
  logic signed [VW-1:0] val_r;
  logic signed [VW-1:0] val2_r;
  logic signed [VW-1:0] lc_r;
  logic                 has_r_r;
  logic                 full_r;
  logic signed [VW-1:0] lo_top_r;
  logic signed [VW-1:0] up_top_r;
  logic [SW-1:0]        lsize_r;
  logic [SW-1:0]        usize_r;

  logic [63:0]          s64;
  logic signed [VW-1:0] key;
  logic [SW-1:0]        count;
  logic [SW-1:0]        pm1;
  logic [SW-1:0]        par;
  logic [PW-1:0]        lidx;
  logic [PW-1:0]        ridx;
  logic [PW-1:0]        nsz;
  logic signed [VW-1:0] hrd;
  logic                 up_ahead;
  logic                 l_ahead;
  logic signed [VW-1:0] bv1;
  logic                 r_ahead;
  logic                 dn_stop;
  logic [SW-1:0]        best;
  logic signed [VW-1:0] bestv;
  logic signed [63:0]   m64;
  logic [63:0]          c64;

  // sample to key, index arithmetic and comparisons
  always_comb begin
    s64      = {{48{in_sample[15]}}, in_sample};
    key      = s64[VW-1:0];
    count    = lsize_r + usize_r;
    pm1      = pos_r - 1'b1;
    par      = {1'b0, pm1[SW-1:1]};
    lidx     = {pos_r, 1'b1};
    ridx     = lidx + 1'b1;
    nsz      = sel_r ? PW'(usize_r) : PW'(lsize_r);
    hrd      = sel_r ? up_rdata : lo_rdata;
    up_ahead = sel_r ? (val_r < hrd) : (val_r > hrd);
    l_ahead  = sel_r ? (lc_r < val_r) : (lc_r > val_r);
    bv1      = l_ahead ? lc_r : val_r;
    r_ahead  = has_r_r && (sel_r ? (hrd < bv1) : (hrd > bv1));
    dn_stop  = !l_ahead && !r_ahead;
    best     = r_ahead ? ridx[SW-1:0] : lidx[SW-1:0];
    bestv    = r_ahead ? hrd : lc_r;
    m64      = 64'(lo_top_r);
    c64      = 64'(count);
  end

  // memory port drive
  always_comb begin
    lo_we = 1'b0;
    up_we = 1'b0;
    waddr = pos_r;
    wdata = val_r;
    raddr = par;
    case (state_r)
      ST_UP_RD: begin
        lo_we = (pos_r == '0) && !sel_r;
        up_we = (pos_r == '0) && sel_r;
      end
      ST_UP_CMP: begin
        lo_we = !sel_r;
        up_we = sel_r;
        wdata = up_ahead ? hrd : val_r;
      end
      ST_DN_RL: begin
        lo_we = (lidx >= nsz) && !sel_r;
        up_we = (lidx >= nsz) && sel_r;
        raddr = lidx[SW-1:0];
      end
      ST_DN_RR: begin
        raddr = ridx[SW-1:0];
      end
      ST_DN_CMP: begin
        lo_we = !sel_r;
        up_we = sel_r;
        wdata = dn_stop ? val_r : bestv;
      end
      default: begin
      end
    endcase
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_DONE);
  assign res.median       = m64[15:0];
  assign res.stored_count = c64[10:0];
  assign res.full_res     = full_r;

  // sequencer, sizes and cached tops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      lsize_r <= '0;
      usize_r <= '0;
      full_r  <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            val_r <= key;
            if (count >= SW'(CAPACITY)) begin
              full_r  <= 1'b1;
              state_r <= ST_DONE;
            end else begin
              full_r  <= 1'b0;
              state_r <= ST_UP_RD;
              if (lsize_r > usize_r) begin
                sel_r   <= 1'b1;
                pos_r   <= usize_r;
                usize_r <= usize_r + 1'b1;
              end else begin
                sel_r   <= 1'b0;
                pos_r   <= lsize_r;
                lsize_r <= lsize_r + 1'b1;
              end
            end
          end
        end
        // hole at pos: root placement or fetch parent
        ST_UP_RD: begin
          if (pos_r == '0) begin
            if (sel_r) begin
              up_top_r <= val_r;
            end else begin
              lo_top_r <= val_r;
            end
            state_r <= ST_SW_CHK;
          end else begin
            state_r <= ST_UP_CMP;
          end
        end
        ST_UP_CMP: begin
          if (up_ahead) begin
            pos_r   <= par;
            state_r <= ST_UP_RD;
          end else begin
            state_r <= ST_SW_CHK;
          end
        end
        // trade tops when out of order
        ST_SW_CHK: begin
          if ((lsize_r != '0) && (usize_r != '0) && (lo_top_r > up_top_r)) begin
            sel_r   <= 1'b0;
            pos_r   <= '0;
            val_r   <= up_top_r;
            val2_r  <= lo_top_r;
            state_r <= ST_DN_RL;
          end else begin
            state_r <= ST_DONE;
          end
        end
        ST_DN_RL: begin
          if (lidx >= nsz) begin
            if (pos_r == '0) begin
              if (sel_r) begin
                up_top_r <= val_r;
              end else begin
                lo_top_r <= val_r;
              end
            end
            if (sel_r) begin
              state_r <= ST_DONE;
            end else begin
              sel_r   <= 1'b1;
              pos_r   <= '0;
              val_r   <= val2_r;
              state_r <= ST_DN_RL;
            end
          end else begin
            state_r <= ST_DN_RR;
          end
        end
        ST_DN_RR: begin
          lc_r    <= hrd;
          has_r_r <= (ridx < nsz);
          state_r <= ST_DN_CMP;
        end
        ST_DN_CMP: begin
          if (pos_r == '0) begin
            if (sel_r) begin
              up_top_r <= dn_stop ? val_r : bestv;
            end else begin
              lo_top_r <= dn_stop ? val_r : bestv;
            end
          end
          if (!dn_stop) begin
            pos_r   <= best;
            state_r <= ST_DN_RL;
          end else if (sel_r) begin
            state_r <= ST_DONE;
          end else begin
            sel_r   <= 1'b1;
            pos_r   <= '0;
            val_r   <= val2_r;
            state_r <= ST_DN_RL;
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  `RMH_ASSERT_ALWAYS(a_balance, (lsize_r == usize_r) || (lsize_r == usize_r + 1'b1), "heap sizes out of balance")
  `RMH_ASSERT_ALWAYS(a_cap, count <= SW'(CAPACITY), "stored count above capacity")
  `RMH_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "second sample taken while busy")
  `RMH_ASSERT_NEXT(a_hold, res_valid && !res_ready, res_valid && $stable(res), "result changed while held")

endmodule
`default_nettype wire

### rtl/running_median_two_heaps.sv
// ----------------------------------------------------------------------------
// running_median_two_heaps
// streaming running lower median over signed samples, two-heap store
// ----------------------------------------------------------------------------
// usage:
//   in_* carries one 16-bit signed sample per beat; out_* returns one result
//   beat per sample: the lower median of all stored samples, the stored
//   count and, on tuser, a flag that the sample was dropped at capacity.
//   samples sit in two single-port-read memories (max-heap of the lower
//   half, min-heap of the upper half); a sequencer inserts by sift-up and,
//   when the tops are out of order, trades them and repairs both heaps by
//   sift-down. one item at a time is in work.
//   a dropped sample goes from the accepted beat straight to its result;
//   an insert walks the sift-up levels and, after a trade, the sift-down
//   levels of each heap, one read a cycle.
//   a finished result waits in an output register, so the next sample is
//   taken while out_tready is low; the sequencer then holds its result
//   until the register frees up.
//   reset (rst_n low, synchronous) empties both heaps; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module running_median_two_heaps #(
  parameter int unsigned CAPACITY    = 1024,
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] sample
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [15:0] median, [26:16] stored_count, rest zero
  output logic [0:0]       out_tuser   // [0] full_res
);

  localparam int unsigned SW  = $clog2(CAPACITY + 1);
  localparam int unsigned LD  = (CAPACITY + 1) / 2;
  localparam int unsigned UD  = CAPACITY / 2;
  localparam int unsigned LAW = (LD > 1) ? $clog2(LD) : 1;
  localparam int unsigned UAW = (UD > 1) ? $clog2(UD) : 1;

  logic                   lo_we;
  logic                   up_we;
  logic [SW-1:0]          waddr;
  logic [VALUE_WIDTH-1:0] wdata;
  logic [SW-1:0]          raddr;
  logic [VALUE_WIDTH-1:0] lo_rdata;
  logic [VALUE_WIDTH-1:0] up_rdata;
  logic                   res_valid;
  logic                   res_ready;
  rmh_pkg::result_t       res;
  rmh_pkg::result_t       out_r;
  logic                   out_valid_r;

  rmh_ram #(.DEPTH(LD), .WIDTH(VALUE_WIDTH)) u_lo_ram (
    .clk   (clk),
    .we    (lo_we),
    .waddr (waddr[LAW-1:0]),
    .wdata (wdata),
    .raddr (raddr[LAW-1:0]),
    .rdata (lo_rdata)
  );

  rmh_ram #(.DEPTH(UD), .WIDTH(VALUE_WIDTH)) u_up_ram (
    .clk   (clk),
    .we    (up_we),
    .waddr (waddr[UAW-1:0]),
    .wdata (wdata),
    .raddr (raddr[UAW-1:0]),
    .rdata (up_rdata)
  );

  rmh_ctrl #(.CAPACITY(CAPACITY), .VALUE_WIDTH(VALUE_WIDTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_sample (in_tdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .lo_we     (lo_we),
    .up_we     (up_we),
    .waddr     (waddr),
    .wdata     (wdata),
    .raddr     (raddr),
    .lo_rdata  (lo_rdata),
    .up_rdata  (up_rdata)
  );

  // output register
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_r.stored_count, out_r.median};
  assign out_tuser  = out_r.full_res;

endmodule
`default_nettype wire
